>>> hdl/stli_pkg.sv
`default_nettype none
package stli_pkg;
  localparam int unsigned MaxPoints = 32;
  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatRange = 2'd1;
  localparam logic [1:0] StatStored = 2'd2;
  localparam logic [1:0] StatFull = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StShift,
    StScan,
    StDiv,
    StOut
  } state_e;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic        shift;   // insert: the cell at the slot takes the new value, cells after it the left value
    logic        rotate;  // scan: every cell takes the value of its right neighbor
    logic signed [15:0] ins_angle;
    logic signed [15:0] ins_coeff;
  } cell_ctrl_t;
endpackage
`default_nettype wire

>>> hdl/stli_cell.sv
`default_nettype none
module stli_cell
  import stli_pkg::*;
(
  input  wire logic               clk_i,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic               left_valid_i,
  input  wire logic               left_gt_i,
  input  wire logic signed [15:0] left_angle_i,
  input  wire logic signed [15:0] left_coeff_i,
  input  wire logic signed [15:0] right_angle_i,
  input  wire logic signed [15:0] right_coeff_i,
  input  wire logic               valid_i,
  output logic                    gt_o,
  output logic signed [15:0]      angle_o,
  output logic signed [15:0]      coeff_o
);
  logic signed [15:0] angle_q, angle_d;
  logic signed [15:0] coeff_q, coeff_d;

  // A valid entry whose angle is above the new one moves right.
  assign gt_o    = valid_i && (angle_q > ctrl_i.ins_angle);
  assign angle_o = angle_q;
  assign coeff_o = coeff_q;

  always_comb begin
    angle_d = angle_q;
    coeff_d = coeff_q;
    if (ctrl_i.rotate) begin
      angle_d = right_angle_i;
      coeff_d = right_coeff_i;
    end else if (ctrl_i.shift) begin
      if (gt_o || !valid_i) begin
        if (left_gt_i && left_valid_i) begin
          angle_d = left_angle_i;
          coeff_d = left_coeff_i;
        end else if (!valid_i && left_valid_i && !left_gt_i || gt_o) begin
          angle_d = ctrl_i.ins_angle;
          coeff_d = ctrl_i.ins_coeff;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
    coeff_q <= coeff_d;
  end
endmodule
`default_nettype wire

>>> hdl/stli_div.sv
`default_nettype none
module stli_div
  import stli_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [32:0] num_i,
  input  wire logic        [16:0] den_i,
  output logic                    done_o,
  output logic signed [32:0]      quo_o
);
  logic [32:0] rem_q, rem_d;
  logic [32:0] quo_q, quo_d;
  logic [16:0] den_q;
  logic        neg_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q;
  logic [33:0] trial;

  always_comb begin
    trial = {rem_q, quo_q[32]} - {17'd0, den_q};
    rem_d = rem_q;
    quo_d = quo_q;
    if (!trial[33]) begin
      rem_d = trial[32:0];
      quo_d = {quo_q[31:0], 1'b1};
    end else begin
      rem_d = {rem_q[31:0], quo_q[32]};
      quo_d = {quo_q[31:0], 1'b0};
    end
    cnt_d = cnt_q - 6'd1;
  end

  assign done_o = busy_q && (cnt_q == 6'd0);
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd33;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[32] ? 33'(-num_i) : 33'(num_i);
      neg_q <= num_i[32];
      den_q <= den_i;
    end else if (busy_q && cnt_q != 6'd0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end
endmodule
`default_nettype wire

>>> hdl/sorted_table_linear_interpolator_unit.sv
`default_nettype none
// Sorted breakpoint table with linear interpolation; one beat is in flight at a time.
// A load passes through the shift state to the output state; a query rotates the cell
// chain through a full MaxPoints-step turn in the scan state and, if it interpolates,
// then runs the restoring divider, before the output state.
// A new beat is not taken until the last result has been accepted on the output.
// Reset (rst_ni low, asynchronous) empties the table and drops the result valid.
module sorted_table_linear_interpolator_unit
  import stli_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // angle_value[15:0], coeff_value[31:16]
  input  wire logic        s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // result_coeff[15:0], status[17:16], zero fill
);
  state_e state_q, state_d;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] step_q;
  logic signed [15:0] x_q, c_q;
  logic [15:0]     res_q;
  logic [1:0]      stat_q;
  logic            found_q;      // answer settled during scan
  logic            need_div_q;
  logic signed [15:0] lo_a_q, lo_c_q, hi_a_q, hi_c_q;
  logic            out_v_q;

  cell_ctrl_t ctrl;
  logic signed [15:0] ang [MaxPoints];
  logic signed [15:0] cof [MaxPoints];
  logic [MaxPoints-1:0] gt, vld;

  // A load into a full table leaves the cells untouched.
  assign ctrl.ins_angle = x_q;
  assign ctrl.ins_coeff = c_q;
  assign ctrl.shift     = (state_q == StShift) && (stat_q == StatStored);
  assign ctrl.rotate    = (state_q == StScan);

  for (genvar k = 0; k < MaxPoints; k++) begin : g_cell
    assign vld[k] = (CntW'(k) < count_q);
    stli_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .left_valid_i  ((k == 0) ? 1'b1 : vld[(k == 0) ? 0 : k-1]),
      .left_gt_i     ((k == 0) ? 1'b0 : gt[(k == 0) ? 0 : k-1]),
      .left_angle_i  (ang[(k == 0) ? 0 : k-1]),
      .left_coeff_i  (cof[(k == 0) ? 0 : k-1]),
      .right_angle_i (ang[(k + 1) % MaxPoints]),
      .right_coeff_i (cof[(k + 1) % MaxPoints]),
      .valid_i       (vld[k]),
      .gt_o          (gt[k]),
      .angle_o       (ang[k]),
      .coeff_o       (cof[k])
    );
  end

  // During the scan cell 0 shows entry step_q and cell 1 entry step_q+1.
  logic in_pair;
  assign in_pair = (CntW'(step_q) + CntW'(1)) < count_q;

  logic div_start, div_done;
  logic signed [32:0] div_num, div_quo;
  logic [16:0] div_den;
  assign div_num = 33'(($signed({x_q[15], x_q}) - $signed({lo_a_q[15], lo_a_q}))
                 * ($signed({hi_c_q[15], hi_c_q}) - $signed({lo_c_q[15], lo_c_q})));
  assign div_den = 17'($signed({hi_a_q[15], hi_a_q}) - $signed({lo_a_q[15], lo_a_q}));
  assign div_start = (state_q == StScan) && (state_d == StDiv);

  stli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic accept;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'd0, stat_q, res_q};

  // Range checks use the live table before the scan starts rotating it.
  logic [IdxW-1:0] last_idx;
  logic qbad;
  assign last_idx = IdxW'(count_q - CntW'(1));
  assign qbad = (count_q == '0) || (x_q < ang[0]) || (x_q > ang[last_idx]);

  // The scan always runs a full MaxPoints-step turn so that the table returns to
  // its home order, even when the answer is settled in the first steps.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = s_axis_tuser ? StScan : StShift;
      StShift: state_d = StOut;
      StScan: begin
        if (step_q == IdxW'(MaxPoints - 1)) state_d = need_div_q ? StDiv : StOut;
      end
      StDiv:   if (div_done) state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut) out_v_q <= 1'b1;
      else if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      if (state_q == StShift && stat_q == StatStored) count_q <= count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (accept) begin
        x_q        <= s_axis_tdata[15:0];
        c_q        <= s_axis_tdata[31:16];
        step_q     <= '0;
        found_q    <= 1'b0;
        need_div_q <= 1'b0;
        res_q      <= '0;
        stat_q     <= s_axis_tuser ? StatOk
                    : ((count_q >= CntW'(MaxPoints)) ? StatFull : StatStored);
      end
      StScan: begin
        step_q <= step_q + IdxW'(1);
        if (step_q == '0 && qbad) begin
          found_q <= 1'b1;
          stat_q  <= StatRange;
        end else if (step_q == '0 && x_q != ang[0] && x_q == ang[last_idx]) begin
          // Hit on last angle but not first: last entry answers, even among duplicates.
          found_q <= 1'b1;
          res_q   <= cof[last_idx];
        end else if (!found_q && !need_div_q) begin
          if (x_q == ang[0]) begin
            found_q <= 1'b1;
            res_q   <= cof[0];
          end else if (in_pair && ang[0] < x_q && x_q < ang[1]) begin
            need_div_q <= 1'b1;
            lo_a_q <= ang[0]; lo_c_q <= cof[0];
            hi_a_q <= ang[1]; hi_c_q <= cof[1];
          end
        end
      end
      StDiv: if (div_done) res_q <= 16'(lo_c_q + div_quo[15:0]);
      default: ;
    endcase
  end
endmodule
`default_nettype wire
